// File: src/led_digit_command_writer_defines.svh
// Assertion macros for the LED digit command writer.
// Used by the top level only; define NO_ASSERTIONS to compile them away.
`ifndef LED_DIGIT_COMMAND_WRITER_DEFINES_SVH
`define LED_DIGIT_COMMAND_WRITER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LDCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define LDCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LDCW_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LDCW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/ldcw_pkg.sv
// Types, constants and byte generation for the LED digit command writer.
// No dependencies; used by every module of the block.
package ldcw_pkg;

	localparam int DIGIT_COUNT = 8;

	localparam logic [7:0] CMD_FIXED_ADDR = 8'h44;
	localparam logic [7:0] CMD_INC_ADDR   = 8'h40;
	localparam logic [7:0] CMD_ADDR_BASE  = 8'hc0;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h8f;
	localparam logic [7:0] LOW_NIBBLE     = 8'h0f;
	localparam logic [7:0] HIGH_NIBBLE    = 8'hf0;

	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] DIGIT_LAST_STEP = 5'd5;
	localparam logic [STEP_W-1:0] CLEAR_LAST_STEP = 5'd18;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_ANODE_TABLE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS  = 2'd1;

	typedef enum logic [1:0] {
		KIND_DIGIT,
		KIND_CLEAR,
		KIND_REJECT
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  code;
		logic [3:0]  base;
	} desc_t;

	typedef struct packed {
		logic [7:0] bus_byte;
		logic       byte_valid;
		logic       new_frame;
		logic       last;
		logic       status;
	} result_t;

	function automatic logic [7:0] seg_code(input logic anode, input logic [3:0] digit);
		logic [7:0] c;
		unique case (digit)
			4'd0: c = 8'h3f;
			4'd1: c = 8'h06;
			4'd2: c = 8'h5b;
			4'd3: c = 8'h4f;
			4'd4: c = 8'h66;
			4'd5: c = 8'h6d;
			4'd6: c = 8'h7d;
			4'd7: c = 8'h07;
			4'd8: c = 8'h7f;
			4'd9: c = 8'h6f;
			default: c = 8'h00;
		endcase
		// Common-anode codes are the complement of the common-cathode ones.
		return anode ? ~c : c;
	endfunction

	function automatic result_t make_result(input desc_t d, input logic [STEP_W-1:0] step,
		input logic [7:0] brightness);
		result_t r;
		r = '{bus_byte: 8'h00, byte_valid: 1'b1, new_frame: 1'b0, last: 1'b0, status: 1'b0};
		unique case (d.kind)
			KIND_DIGIT: begin
				priority if (step == 5'd0) begin
					r.bus_byte = CMD_FIXED_ADDR;
					r.new_frame = 1'b1;
				end else if (step == 5'd1) begin
					r.bus_byte = CMD_ADDR_BASE | {4'h0, d.base};
					r.new_frame = 1'b1;
				end else if (step == 5'd2) begin
					r.bus_byte = d.code & LOW_NIBBLE;
				end else if (step == 5'd3) begin
					r.bus_byte = CMD_ADDR_BASE | {4'h0, d.base | 4'h1};
					r.new_frame = 1'b1;
				end else if (step == 5'd4) begin
					r.bus_byte = (d.code & HIGH_NIBBLE) >> 4;
				end else begin
					r.bus_byte = CMD_DISPLAY_ON;
					r.new_frame = 1'b1;
					r.last = 1'b1;
				end
			end
			KIND_CLEAR: begin
				priority if (step == 5'd0) begin
					r.bus_byte = CMD_INC_ADDR;
					r.new_frame = 1'b1;
				end else if (step == 5'd1) begin
					r.bus_byte = CMD_ADDR_BASE;
					r.new_frame = 1'b1;
				end else if (step == CLEAR_LAST_STEP) begin
					r.bus_byte = brightness;
					r.new_frame = 1'b1;
					r.last = 1'b1;
				end else begin
					r.bus_byte = 8'h00;
				end
			end
			default: begin
				r.byte_valid = 1'b0;
				r.last = 1'b1;
				r.status = 1'b1;
			end
		endcase
		return r;
	endfunction

endpackage

// File: src/ldcw_front.sv
// Front end: checks and classifies one request into a command descriptor.
// Depends on ldcw_pkg.
module ldcw_front import ldcw_pkg::*; (
	input  logic       mode,
	input  logic [3:0] position,
	input  logic [3:0] digit,
	input  logic       anode_table,
	output desc_t      desc
);

	logic in_range;

	always_comb begin
		in_range = (position >= 4'd1) && (position <= 4'(DIGIT_COUNT)) && (digit <= 4'd9);
		desc.code = seg_code(anode_table, digit);
		desc.base = {position[2:0] - 3'd1, 1'b0};
		priority if (mode) begin
			desc.kind = KIND_CLEAR;
		end else if (in_range) begin
			desc.kind = KIND_DIGIT;
		end else begin
			desc.kind = KIND_REJECT;
		end
	end

endmodule

// File: src/ldcw_queue.sv
// Short descriptor queue between the front end and the byte sequencer.
// Depends on ldcw_pkg.
module ldcw_queue import ldcw_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  desc_t                      wr_data,
	input  logic                       rd_en,
	output desc_t                      rd_data,
	output logic                       q_full,
	output logic                       q_empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	desc_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == CNT_W'(DEPTH));
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: src/ldcw_back.sv
// Back end: steps through a descriptor one byte item at a time into an output register.
// Depends on ldcw_pkg.
module ldcw_back import ldcw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  desc_t      q_data,
	output logic       q_pop,
	input  logic [7:0] brightness,
	input  logic       pop,
	output logic       empty,
	output result_t    result
);

	desc_t             cur_q;
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	result_t           out_q;
	result_t           res_now;
	logic              emit;

	always_comb begin
		res_now = make_result(cur_q, step_q, brightness);
		emit    = busy_q && (!out_valid_q || pop);
		q_pop   = !busy_q && !q_empty;
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (emit) begin
			out_q <= res_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (emit) begin
				if (res_now.last) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/led_digit_command_writer.sv
// Top level of the LED digit command writer: configuration registers and the
// front end, descriptor queue and byte sequencer. Depends on ldcw_pkg and the defines header.
//
//   channel   handshake        payload
//   request   push / full      mode, position, digit
//   result    pop / empty      bus_byte, byte_valid, new_frame, last, status
//   config    cfg_we           cfg_index, cfg_data
//
// A request is taken in any cycle in which the queue has room. The sequencer
// gives one byte item per cycle while pop is held: six for a digit write,
// nineteen for a clear and one for a rejected request; each descriptor is
// fetched from the queue only while the sequencer is idle. Reset empties the
// queue and output register and restores common-cathode codes and brightness 0x8f.
`include "led_digit_command_writer_defines.svh"
module led_digit_command_writer import ldcw_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic                   mode,
	input  logic [3:0]             position,
	input  logic [3:0]             digit,
	input  logic                   pop,
	output logic                   empty,
	output logic [7:0]             bus_byte,
	output logic                   byte_valid,
	output logic                   new_frame,
	output logic                   last,
	output logic                   status,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic             anode_q;
	logic [7:0]       brightness_q;
	desc_t            front_desc;
	desc_t            q_data;
	logic             q_empty;
	logic             q_pop;
	logic [CNT_W-1:0] q_count;
	result_t          result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anode_q      <= 1'b0;
			brightness_q <= CMD_DISPLAY_ON;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ANODE_TABLE: anode_q <= cfg_data[0];
				REG_BRIGHTNESS:  brightness_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ldcw_front u_front (
		.mode        (mode),
		.position    (position),
		.digit       (digit),
		.anode_table (anode_q),
		.desc        (front_desc)
	);

	ldcw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && !full),
		.wr_data (front_desc),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.q_full  (full),
		.q_empty (q_empty),
		.count   (q_count)
	);

	ldcw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.brightness (brightness_q),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

	assign bus_byte   = result.bus_byte;
	assign byte_valid = result.byte_valid;
	assign new_frame  = result.new_frame;
	assign last       = result.last;
	assign status     = result.status;

	`LDCW_ASSERT_NOW(a_reject_alone, clk, arst_n, !empty && status, last && !byte_valid && !new_frame)
	`LDCW_ASSERT_NOW(a_queue_bound, clk, arst_n, 1'b1, q_count <= CNT_W'(QUEUE_DEPTH))
	`LDCW_ASSERT_NEXT(a_push_lands, clk, arst_n, push && !full && !q_pop, q_count == $past(q_count) + CNT_W'(1))
	`LDCW_ASSERT_NOW(a_no_fetch_empty, clk, arst_n, q_pop, q_count != '0)

endmodule

// File: sim/tb.sv
// Self-checking testbench for led_digit_command_writer: digit writes, clears and
// rejected requests under several register settings, with random push and pop timing.
// Depends on ldcw_pkg and the RTL top level only.
module tb;
	import ldcw_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PER_PHASE = 40;
	localparam int REPORT_LIMIT = 10;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic [9:0][7:0] CATHODE_SEG = {
		8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
	};
	localparam logic [9:0][7:0] ANODE_SEG = {
		8'h90, 8'h80, 8'hf8, 8'h82, 8'h92, 8'h99, 8'hb0, 8'ha4, 8'hf9, 8'hc0
	};

	class byte_stream_board;
		logic anode;
		logic [7:0] brightness;
		result_t pending_bytes[$];
		int errors;
		int bytes_checked;
		int digit_writes;
		int clears;
		int rejects;

		function new();
			anode = 1'b0;
			brightness = CMD_DISPLAY_ON;
			errors = 0;
			bytes_checked = 0;
			digit_writes = 0;
			clears = 0;
			rejects = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [7:0] data);
			case (index)
				REG_ANODE_TABLE: anode = data[0];
				REG_BRIGHTNESS: brightness = data;
				default: ;
			endcase
		endfunction

		function void add_byte(logic [7:0] b, logic v, logic f, logic l, logic s);
			result_t r;
			r.bus_byte = b;
			r.byte_valid = v;
			r.new_frame = f;
			r.last = l;
			r.status = s;
			pending_bytes.push_back(r);
		endfunction

		function void note_request(logic m, logic [3:0] p, logic [3:0] d);
			logic [7:0] seg;
			logic [3:0] base;
			if (m) begin
				clears++;
				add_byte(CMD_INC_ADDR, 1'b1, 1'b1, 1'b0, 1'b0);
				add_byte(CMD_ADDR_BASE, 1'b1, 1'b1, 1'b0, 1'b0);
				for (int i = 0; i < 16; i++)
					add_byte(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
				add_byte(brightness, 1'b1, 1'b1, 1'b1, 1'b0);
			end else if (p < 4'd1 || p > DIGIT_COUNT || d > 4'd9) begin
				rejects++;
				add_byte(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
			end else begin
				digit_writes++;
				seg = anode ? ANODE_SEG[d] : CATHODE_SEG[d];
				base = (p - 4'd1) << 1;
				add_byte(CMD_FIXED_ADDR, 1'b1, 1'b1, 1'b0, 1'b0);
				add_byte(CMD_ADDR_BASE | {4'h0, base}, 1'b1, 1'b1, 1'b0, 1'b0);
				add_byte({4'h0, seg[3:0]}, 1'b1, 1'b0, 1'b0, 1'b0);
				add_byte(CMD_ADDR_BASE | {4'h0, base + 4'd1}, 1'b1, 1'b1, 1'b0, 1'b0);
				add_byte({4'h0, seg[7:4]}, 1'b1, 1'b0, 1'b0, 1'b0);
				add_byte(CMD_DISPLAY_ON, 1'b1, 1'b1, 1'b1, 1'b0);
			end
		endfunction

		function void check_byte(result_t got);
			result_t want;
			bytes_checked++;
			if (pending_bytes.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected byte item %02h valid %0b frame %0b last %0b status %0b",
						got.bus_byte, got.byte_valid, got.new_frame, got.last, got.status);
				return;
			end
			want = pending_bytes.pop_front();
			if (got.bus_byte !== want.bus_byte || got.byte_valid !== want.byte_valid ||
				got.new_frame !== want.new_frame || got.last !== want.last ||
				got.status !== want.status) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("byte item %0d: expected %02h/%0b/%0b/%0b/%0b got %02h/%0b/%0b/%0b/%0b",
						bytes_checked, want.bus_byte, want.byte_valid, want.new_frame,
						want.last, want.status, got.bus_byte, got.byte_valid,
						got.new_frame, got.last, got.status);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic mode = 1'b0;
	logic [3:0] position = 4'd0;
	logic [3:0] digit = 4'd0;
	logic pop = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = 8'h00;
	logic full;
	logic empty;
	logic [7:0] bus_byte;
	logic byte_valid;
	logic new_frame;
	logic last;
	logic status;

	byte_stream_board board = new();
	int burst_left = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	int rx_style = 0;
	int rx_span = 0;
	int phases = 0;

	led_digit_command_writer dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mode(mode),
		.position(position),
		.digit(digit),
		.pop(pop),
		.empty(empty),
		.bus_byte(bus_byte),
		.byte_valid(byte_valid),
		.new_frame(new_frame),
		.last(last),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (cfg_we)
				board.write_reg(cfg_index, cfg_data);
			if (push && !full)
				board.note_request(mode, position, digit);
			if (pop && !empty) begin
				got.bus_byte = bus_byte;
				got.byte_valid = byte_valid;
				got.new_frame = new_frame;
				got.last = last;
				got.status = status;
				board.check_byte(got);
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rx_span == 0) begin
			rx_style <= $urandom_range(0, 2);
			rx_span <= $urandom_range(50, 300);
		end else begin
			rx_span <= rx_span - 1;
		end
		if (stall_left != 0) begin
			pop <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			pop <= 1'b1;
			case (rx_style)
				1: stall_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
				2: stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : 0;
				default: stall_left <= 0;
			endcase
		end
	end

	task automatic send_item(input logic m, input logic [3:0] p, input logic [3:0] d);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		mode <= m;
		position <= p;
		digit <= d;
		do @(posedge clk); while (full);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (board.pending_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input logic [7:0] anode_data, input logic [7:0] bright_data);
		int pick;
		logic m;
		logic [3:0] p;
		logic [3:0] d;
		wait_drained();
		write_reg(REG_ANODE_TABLE, anode_data);
		write_reg(REG_BRIGHTNESS, bright_data);
		phases++;
		for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
			pick = $urandom_range(0, 99);
			m = 1'b0;
			p = 4'($urandom_range(1, DIGIT_COUNT));
			d = 4'($urandom_range(0, 9));
			if (pick >= 60 && pick < 75) begin
				m = 1'b1;
				p = 4'($urandom);
				d = 4'($urandom);
			end else if (pick >= 75 && pick < 83) begin
				p = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
			end else if (pick >= 83 && pick < 91) begin
				d = 4'($urandom_range(10, 15));
			end else if (pick >= 91) begin
				p = 4'($urandom);
				d = 4'($urandom);
			end
			send_item(m, p, d);
			if (n == RANDOM_PER_PHASE / 2 && phases == 2)
				wait_drained();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int d = 0; d < 10; d++)
			send_item(1'b0, 4'((d % DIGIT_COUNT) + 1), 4'(d));
		send_item(1'b0, 4'd0, 4'd5);
		send_item(1'b0, 4'd9, 4'd3);
		send_item(1'b0, 4'd15, 4'd0);
		send_item(1'b0, 4'd3, 4'd10);
		send_item(1'b0, 4'd4, 4'd15);
		send_item(1'b0, 4'd0, 4'd15);
		send_item(1'b1, 4'd0, 4'd0);
		send_item(1'b1, 4'd15, 4'd15);
		send_item(1'b1, 4'd5, 4'd12);
		phases++;

		wait_drained();
		write_reg(REG_SPARE_2, 8'($urandom));
		write_reg(REG_SPARE_3, 8'($urandom));
		random_phase(8'hff, 8'h80);
		random_phase(8'hfe, 8'hff);
		random_phase(8'h01, 8'h00);
		random_phase(8'h00, 8'h8f);
		random_phase(8'($urandom), 8'($urandom_range(128, 143)));

		wait_drained();
		repeat (20) @(posedge clk);
		if (board.pending_bytes.size() != 0) begin
			board.errors++;
			$display("%0d expected byte items never arrived", board.pending_bytes.size());
		end
		$display("Covered %0d digit writes, %0d clears and %0d rejected requests",
			board.digit_writes, board.clears, board.rejects);
		$display("over %0d register settings; %0d byte items checked, %0d mismatches",
			phases, board.bytes_checked, board.errors);
		if (board.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
